// ===== rtl/mrbe_pkg.sv =====
package mrbe_pkg;

    // Field and register widths
    localparam int ROW_W      = 9;
    localparam int COL_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 16;
    localparam int PIX_PER_B  = 8;
    localparam int BAND_ROW_W = 10;
    localparam int CFG_DATA_W = 52;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 3;
    localparam int DEFCOL_W   = 32;

    // Parameter defaults
    localparam int PANEL_ROWS_DEF = 320;
    localparam int ROW_BYTES_DEF  = 40;
    localparam int MAX_BANDS_DEF  = 6;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLORS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT     = 3'd1;
    localparam int                   REG_BAND_BASE      = 2;

    // Foreground / background pair
    typedef struct packed {
        logic [PIX_W-1:0] fg;
        logic [PIX_W-1:0] bg;
    } color_pair_t;

    // One row band, packed as in its register
    typedef struct packed {
        logic [BAND_ROW_W-1:0] start_row;
        logic [BAND_ROW_W-1:0] end_row;
        color_pair_t           colors;
    } band_t;

    // Swap to panel big-endian byte order
    function automatic logic [PIX_W-1:0] swap_bytes(input logic [PIX_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

// ===== rtl/mrbe_pixel_expand.sv =====
module mrbe_pixel_expand #(
    parameter int MAX_BANDS = mrbe_pkg::MAX_BANDS_DEF
) (
    input  logic [mrbe_pkg::ROW_W-1:0]                      row,
    input  logic [mrbe_pkg::BYTE_W-1:0]                     mono_byte,
    input  mrbe_pkg::color_pair_t                           default_colors,
    input  logic [mrbe_pkg::CNT_W-1:0]                      band_count,
    input  mrbe_pkg::band_t                                 bands [MAX_BANDS],
    output logic [mrbe_pkg::PIX_PER_B-1:0][mrbe_pkg::PIX_W-1:0] pixels
);

    mrbe_pkg::color_pair_t pair;
    logic [mrbe_pkg::BAND_ROW_W-1:0] row_ext;
    logic [mrbe_pkg::PIX_W-1:0] fg_sw;
    logic [mrbe_pkg::PIX_W-1:0] bg_sw;

    assign row_ext = {1'b0, row};

    // Band select: walk from the top so the lowest matching index wins
    always_comb
    begin
        pair = default_colors;
        for (int i = MAX_BANDS - 1; i >= 0; i--)
        begin
            if ((mrbe_pkg::CNT_W'(i) < band_count) &&
                (row_ext >= bands[i].start_row) &&
                (row_ext < bands[i].end_row))
            begin
                pair = bands[i].colors;
            end
        end
    end

    assign fg_sw = mrbe_pkg::swap_bytes(pair.fg);
    assign bg_sw = mrbe_pkg::swap_bytes(pair.bg);

    // Bit k drives pixel k, LSB leftmost
    always_comb
    begin
        for (int k = 0; k < mrbe_pkg::PIX_PER_B; k++)
        begin
            pixels[k] = mono_byte[k] ? fg_sw : bg_sw;
        end
    end

endmodule

// ===== rtl/mono_to_rgb565_band_expander_core.sv =====
// Monochrome bitmap byte to RGB565 pixel expander.
// Input channel (in_valid / in_stall): one bitmap byte with its row and byte
// column per request. Output channel (out_valid / out_stall): eight byte-swapped
// RGB565 pixels, the echoed row and a last-byte-of-row flag per request.
// Colors come from the first enabled row band covering the row, else from the
// default pair. Rows at or beyond PANEL_ROWS and columns at or beyond ROW_BYTES
// are consumed and produce no output request.
// Requests pass the input register, then the result register. Throughput: one
// request per cycle while out_stall is low, set by the combinational band
// compare and pixel select between them. Stall: the result register holds
// while valid and out_stall is high; the input register still takes a request
// if it is empty or its contents can move on, so in_stall rises only when both
// stages are full and the output is stalled. Reset: all configuration registers
// clear to zero and both stages empty. Configuration (cfg_write / cfg_index /
// cfg_data) must be written only while idle; the block does not enforce it.
module mono_to_rgb565_band_expander_core #(
    parameter int PANEL_ROWS = mrbe_pkg::PANEL_ROWS_DEF,
    parameter int ROW_BYTES  = mrbe_pkg::ROW_BYTES_DEF,
    parameter int MAX_BANDS  = mrbe_pkg::MAX_BANDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [mrbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrbe_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mrbe_pkg::ROW_W-1:0]          row,
    input  logic [mrbe_pkg::COL_W-1:0]          byte_column,
    input  logic [mrbe_pkg::BYTE_W-1:0]         mono_byte,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_0,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_1,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_2,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_3,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_4,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_5,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_6,
    output logic [mrbe_pkg::PIX_W-1:0]          pixel_7,
    output logic [mrbe_pkg::ROW_W-1:0]          out_row,
    output logic                                row_end
);

    // Configuration registers
    mrbe_pkg::color_pair_t              default_colors_reg;
    logic [mrbe_pkg::CNT_W-1:0]         band_count_reg;
    mrbe_pkg::band_t                    band_reg [MAX_BANDS];

    // Input stage
    logic                               s1_valid_reg;
    logic [mrbe_pkg::ROW_W-1:0]         s1_row_reg;
    logic [mrbe_pkg::COL_W-1:0]         s1_col_reg;
    logic [mrbe_pkg::BYTE_W-1:0]        s1_byte_reg;

    // Result stage
    logic                               out_valid_reg;
    logic [mrbe_pkg::PIX_PER_B-1:0][mrbe_pkg::PIX_W-1:0] pixel_reg;
    logic [mrbe_pkg::PIX_PER_B-1:0][mrbe_pkg::PIX_W-1:0] pixel_next;
    logic [mrbe_pkg::ROW_W-1:0]         out_row_reg;
    logic                               row_end_reg;
    logic                               row_end_next;

    logic                               out_ready;
    logic                               s1_ready;
    logic                               s1_in_range;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_colors_reg <= '0;
            band_count_reg     <= '0;
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                band_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == mrbe_pkg::REG_DEFAULT_COLORS)
            begin
                default_colors_reg <= cfg_data[mrbe_pkg::DEFCOL_W-1:0];
            end
            if (cfg_index == mrbe_pkg::REG_BAND_COUNT)
            begin
                band_count_reg <= cfg_data[mrbe_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                if (cfg_index == mrbe_pkg::CFG_IDX_W'(mrbe_pkg::REG_BAND_BASE + i))
                begin
                    band_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_row_reg  <= row;
            s1_col_reg  <= byte_column;
            s1_byte_reg <= mono_byte;
        end
    end

    // Drop rows past the panel and columns past the row
    assign s1_in_range = ({1'b0, s1_row_reg} < (mrbe_pkg::ROW_W + 1)'(PANEL_ROWS)) &&
                         ({1'b0, s1_col_reg} < (mrbe_pkg::COL_W + 1)'(ROW_BYTES));
    assign row_end_next = (s1_col_reg == mrbe_pkg::COL_W'(ROW_BYTES - 1));

    mrbe_pixel_expand #(
        .MAX_BANDS(MAX_BANDS)
    ) u_expand (
        .row            (s1_row_reg),
        .mono_byte      (s1_byte_reg),
        .default_colors (default_colors_reg),
        .band_count     (band_count_reg),
        .bands          (band_reg),
        .pixels         (pixel_next)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg && s1_in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            pixel_reg   <= pixel_next;
            out_row_reg <= s1_row_reg;
            row_end_reg <= row_end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_0   = pixel_reg[0];
    assign pixel_1   = pixel_reg[1];
    assign pixel_2   = pixel_reg[2];
    assign pixel_3   = pixel_reg[3];
    assign pixel_4   = pixel_reg[4];
    assign pixel_5   = pixel_reg[5];
    assign pixel_6   = pixel_reg[6];
    assign pixel_7   = pixel_reg[7];
    assign out_row   = out_row_reg;
    assign row_end   = row_end_reg;

    // Assertions
    a_out_row_in_panel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_row} < (mrbe_pkg::ROW_W + 1)'(PANEL_ROWS)))
        else $error("output row beyond panel");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_in_range_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_in_range && out_ready) |=> out_valid)
        else $error("in-range request lost between stages");

endmodule

// ===== verif/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mrbe_pkg::*;

    localparam int PANEL_ROWS = PANEL_ROWS_DEF;
    localparam int ROW_BYTES  = ROW_BYTES_DEF;
    localparam int MAX_BANDS  = MAX_BANDS_DEF;
    localparam int NUM_BANDS  = 6;
    localparam int PHASE_REQS = 85;
    localparam int NUM_PHASES = 12;

    // One bitmap byte request
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] bits;
    } bitmap_req_t;

    // One expanded pixel group
    typedef struct packed {
        logic [PIX_PER_B-1:0][PIX_W-1:0] pixels;
        logic [ROW_W-1:0]                out_row;
        logic                            last_col;
    } pixel_group_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ROW_W-1:0]  row = '0;
    logic [COL_W-1:0]  byte_column = '0;
    logic [BYTE_W-1:0] mono_byte = '0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] pixel_0, pixel_1, pixel_2, pixel_3;
    logic [PIX_W-1:0] pixel_4, pixel_5, pixel_6, pixel_7;
    logic [ROW_W-1:0] out_row;
    logic             row_end;

    // Shadow copy of the configuration
    color_pair_t        dflt_pair = '0;
    logic [CNT_W-1:0]   band_limit = '0;
    band_t              bands [NUM_BANDS];

    bitmap_req_t  byte_requests [$];
    pixel_group_t pixel_expect [$];

    int errors = 0;
    int groups_checked = 0;
    int bytes_dropped = 0;
    int reg_writes = 0;

    mono_to_rgb565_band_expander_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row         (row),
        .byte_column (byte_column),
        .mono_byte   (mono_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_0     (pixel_0),
        .pixel_1     (pixel_1),
        .pixel_2     (pixel_2),
        .pixel_3     (pixel_3),
        .pixel_4     (pixel_4),
        .pixel_5     (pixel_5),
        .pixel_6     (pixel_6),
        .pixel_7     (pixel_7),
        .out_row     (out_row),
        .row_end     (row_end)
    );

    always #5 clk = ~clk;

    // Expand one bitmap byte into its pixel group; 0 when the byte is off-panel
    function automatic bit expand_byte(input bitmap_req_t req, output pixel_group_t grp);
        color_pair_t pair;
        int          limit;
        int          i;
        bit          hit;
        grp = '0;
        if (req.row >= PANEL_ROWS || req.col >= ROW_BYTES)
            return 1'b0;
        pair = dflt_pair;
        limit = (band_limit > MAX_BANDS) ? MAX_BANDS : band_limit;
        hit = 1'b0;
        for (i = 0; i < limit; i++)
        begin
            if (!hit && req.row >= bands[i].start_row && req.row < bands[i].end_row)
            begin
                pair = bands[i].colors;
                hit = 1'b1;
            end
        end
        // panel wants big-endian pixels
        for (i = 0; i < PIX_PER_B; i++)
            grp.pixels[i] = req.bits[i] ? {pair.fg[7:0], pair.fg[15:8]}
                                        : {pair.bg[7:0], pair.bg[15:8]};
        grp.out_row = req.row;
        grp.last_col = (req.col == ROW_BYTES - 1);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h (group %0d)",
                 $realtime, what, got, want, groups_checked);
        errors++;
    endtask

    // Register write; the shadow is updated when the write is driven, before the block takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_DEFAULT_COLORS: dflt_pair = data[DEFCOL_W-1:0];
            REG_BAND_COUNT:     band_limit = data[CNT_W-1:0];
            default:            bands[idx - REG_BAND_BASE] = data;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Block is idle once nothing is queued, in flight or expected
    task automatic wait_idle;
        while (byte_requests.size() != 0 || in_valid || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] make_band(input int kind);
        int s;
        int e;
        case (kind)
            0:
            begin
                s = $urandom_range(0, 300);
                e = $urandom_range(s + 1, 330);
            end
            1:
            begin
                s = $urandom_range(0, 1023);
                e = s;
            end
            2:
            begin
                s = $urandom_range(1, 1023);
                e = $urandom_range(0, s - 1);
            end
            3:
            begin
                s = 0;
                e = 1023;
            end
            default:
                return CFG_DATA_W'({$urandom, $urandom});
        endcase
        return {s[BAND_ROW_W-1:0], e[BAND_ROW_W-1:0], $urandom};
    endfunction

    function automatic logic [BYTE_W-1:0] pick_bits;
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic queue_byte(input int r, input int c, input logic [BYTE_W-1:0] b);
        bitmap_req_t req;
        req.row = ROW_W'(r);
        req.col = COL_W'(c);
        req.bits = b;
        byte_requests.push_back(req);
    endtask

    // Mostly whole or partial row scans, with some scattered and off-panel bytes
    task automatic random_traffic(input int n_on_panel);
        int placed;
        int r;
        int c;
        int c0;
        placed = 0;
        while (placed < n_on_panel)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r = ($urandom_range(0, 19) == 0) ? $urandom_range(PANEL_ROWS, 511)
                                                 : $urandom_range(0, PANEL_ROWS - 1);
                c0 = $urandom_range(0, ROW_BYTES - 1);
                for (c = c0; c < ROW_BYTES; c++)
                begin
                    queue_byte(r, c, pick_bits());
                    if (r < PANEL_ROWS)
                        placed++;
                end
            end
            else
            begin
                r = $urandom_range(0, 511);
                c = $urandom_range(0, 63);
                queue_byte(r, c, pick_bits());
                if (r < PANEL_ROWS && c < ROW_BYTES)
                    placed++;
            end
        end
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bitmap_req_t  req;
        pixel_group_t grp;
        int           burst_left;
        int           gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            row <= '0;
            byte_column <= '0;
            mono_byte <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                req.row = row;
                req.col = byte_column;
                req.bits = mono_byte;
                if (expand_byte(req, grp))
                    pixel_expect.push_back(grp);
                else
                    bytes_dropped++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_requests.size() > 0)
                begin
                    req = byte_requests.pop_front();
                    row <= req.row;
                    byte_column <= req.col;
                    mono_byte <= req.bits;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        pixel_group_t want;
        logic [PIX_W-1:0] got_px [PIX_PER_B];
        int cycle_cnt;
        int stall_mode;
        int hold_cnt;
        logic stall_level;
        logic next_stall;
        int k;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            cycle_cnt = 0;
            stall_mode = 0;
            hold_cnt = 0;
            stall_level = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $display("%0t: result with no pending byte (row %0d)", $realtime, out_row);
                    errors++;
                end
                else
                begin
                    want = pixel_expect.pop_front();
                    got_px = '{pixel_0, pixel_1, pixel_2, pixel_3,
                               pixel_4, pixel_5, pixel_6, pixel_7};
                    for (k = 0; k < PIX_PER_B; k++)
                        if (got_px[k] !== want.pixels[k])
                            report_mismatch($sformatf("pixel_%0d", k), 32'(got_px[k]),
                                            32'(want.pixels[k]));
                    if (out_row !== want.out_row)
                        report_mismatch("out_row", 32'(out_row), 32'(want.out_row));
                    if (row_end !== want.last_col)
                        report_mismatch("row_end", 32'(row_end), 32'(want.last_col));
                    groups_checked++;
                end
            end
            // pick a stall style at random from time to time: none, scattered, long runs
            cycle_cnt++;
            if (cycle_cnt % 100 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: next_stall = 1'b0;
                1: next_stall = ($urandom_range(0, 99) < 35);
                default:
                begin
                    if (hold_cnt == 0)
                    begin
                        hold_cnt = $urandom_range(1, 12);
                        stall_level = ~stall_level;
                    end
                    hold_cnt--;
                    next_stall = stall_level;
                end
            endcase
            out_stall <= next_stall;
        end
    end

    initial
    begin : sequencer
        int p;
        int i;
        int cnt;
        for (i = 0; i < NUM_BANDS; i++)
            bands[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: all colors zero
        queue_byte(0, 0, 8'hFF);
        queue_byte(PANEL_ROWS - 1, ROW_BYTES - 1, 8'h5A);
        wait_idle();

        // directed: band edges, an inverted (empty) band, off-panel bytes
        write_reg(REG_DEFAULT_COLORS, {20'hFFFFF, 32'hF800_001F});
        write_reg(REG_BAND_COUNT, 52'd3);
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 0), {10'd10, 10'd20, 16'h07E0, 16'hFFFF});
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 1), {10'd50, 10'd40, 16'h1111, 16'h2222});
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 2), {10'd100, 10'd200, 16'h1234, 16'hABCD});
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 3), {10'd0, 10'd1023, 16'h3333, 16'h4444});
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 4), {CFG_DATA_W{1'b1}});
        write_reg(CFG_IDX_W'(REG_BAND_BASE + 5), {CFG_DATA_W{1'b1}});
        queue_byte(0, 0, 8'h00);
        queue_byte(9, 1, 8'h01);
        queue_byte(10, 2, 8'h80);
        queue_byte(19, 3, 8'hAA);
        queue_byte(20, 4, 8'h55);
        queue_byte(45, 5, 8'hFF);
        queue_byte(100, 6, 8'h0F);
        queue_byte(199, 7, 8'hF0);
        queue_byte(200, 8, 8'h3C);
        queue_byte(PANEL_ROWS - 1, ROW_BYTES - 1, 8'hC3);
        queue_byte(PANEL_ROWS, 0, 8'hFF);
        queue_byte(511, 63, 8'hFF);
        queue_byte(5, ROW_BYTES, 8'hFF);
        queue_byte(5, 63, 8'h81);
        queue_byte(150, ROW_BYTES - 2, 8'h7E);
        queue_byte(150, ROW_BYTES - 1, 8'h18);
        wait_idle();

        // random phases, each with its own configuration
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                write_reg(REG_DEFAULT_COLORS, {CFG_DATA_W{1'b1}});
                write_reg(REG_BAND_COUNT, {CFG_DATA_W{1'b1}});
                for (i = 0; i < NUM_BANDS; i++)
                    write_reg(CFG_IDX_W'(REG_BAND_BASE + i), {CFG_DATA_W{1'b1}});
            end
            else
            begin
                write_reg(REG_DEFAULT_COLORS,
                          (p == 1) ? 52'd0 : CFG_DATA_W'({$urandom, $urandom}));
                case (p)
                    0:       cnt = 7;
                    1:       cnt = 6;
                    2:       cnt = 0;
                    default: cnt = $urandom_range(0, 7);
                endcase
                write_reg(REG_BAND_COUNT, {$urandom, 20'd0} | CFG_DATA_W'(cnt));
                for (i = 0; i < NUM_BANDS; i++)
                    write_reg(CFG_IDX_W'(REG_BAND_BASE + i),
                              make_band(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
            end
            random_traffic(PHASE_REQS);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d pixel groups, %0d off-panel bytes dropped, %0d register writes",
                 groups_checked, bytes_dropped, reg_writes);
        $display("over %0d configurations; %0d mismatches", NUM_PHASES + 2, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timed out with %0d results still expected", pixel_expect.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
